// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mpu_pkg.sv
// ----------------------------------------------------------------------------
// mpu_pkg
// Types, character constants and keyword tables of the multipart extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package mpu_pkg;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_F  = 8'h66;

    localparam logic [3:0] NAME_KEY_LEN  = 4'd9;
    localparam logic [3:0] BLANK_KEY_LEN = 4'd4;

    typedef enum logic [2:0] {
        PH_CAPTURE,
        PH_FIND_NAME,
        PH_SKIP_LINE,
        PH_FIND_BLANK,
        PH_CONTENT,
        PH_DONE
    } phase_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic restart;  // load cells 0/1 with LF/CR, drop the stored boundary
        logic shift1;   // push one boundary byte in at cell 0
        logic shift2;   // push CR and the byte in at cells 1 and 0
        logic step;     // advance the content window and match flags
        logic clr;      // empty the content window
    } cell_ctrl_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       has;
        logic       done;
        logic       ovf;
    } result_t;

    // "filename="
    function automatic logic [7:0] name_key(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h66;
            4'd1:    c = 8'h69;
            4'd2:    c = 8'h6C;
            4'd3:    c = 8'h65;
            4'd4:    c = 8'h6E;
            4'd5:    c = 8'h61;
            4'd6:    c = 8'h6D;
            4'd7:    c = 8'h65;
            4'd8:    c = 8'h3D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // CR LF CR LF
    function automatic logic [7:0] blank_key(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = CHAR_CR;
            2'd1:    c = CHAR_LF;
            2'd2:    c = CHAR_CR;
            default: c = CHAR_LF;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mpu_cell.sv
// ----------------------------------------------------------------------------
// mpu_cell
// One position of the boundary/window chain: holds the expected byte
// (boundary stored newest first, then LF, CR), the delayed content byte and
// the partial match flag of the running shift-and search.
// ----------------------------------------------------------------------------
`default_nettype none

module mpu_cell
    import mpu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctl,
    input  wire logic [7:0] in_byte,
    input  wire logic       pre_act,
    input  wire logic [7:0] pre_exp,
    input  wire logic       lo1_act,
    input  wire logic [7:0] lo1_exp,
    input  wire logic       lo2_act,
    input  wire logic [7:0] lo2_exp,
    input  wire logic       hi_act,
    input  wire logic [7:0] hi_data,
    input  wire logic       hi_vld,
    input  wire logic       hi_match,
    output logic            base_act,
    output logic [7:0]      base_exp,
    output logic            act,
    output logic [7:0]      data,
    output logic            vld,
    output logic            match,
    output logic            match_next
);

    logic       act_reg, act_next;
    logic [7:0] exp_reg, exp_next;
    logic [7:0] data_reg, data_next;
    logic       vld_reg, vld_next;
    logic       match_reg, match_next_int;
    logic       top;
    logic       hit;

    assign base_act = ctl.restart ? pre_act : act_reg;
    assign base_exp = ctl.restart ? pre_exp : exp_reg;

    // Last cell inside the window span: new content enters here.
    assign top = act_reg & ~hi_act;
    assign hit = (top | hi_match) & (in_byte == exp_reg);

    always_comb
    begin
        if (ctl.shift2)
        begin
            act_next = lo2_act;
            exp_next = lo2_exp;
        end
        else if (ctl.shift1)
        begin
            act_next = lo1_act;
            exp_next = lo1_exp;
        end
        else
        begin
            act_next = base_act;
            exp_next = base_exp;
        end
    end

    always_comb
    begin
        data_next      = data_reg;
        vld_next       = vld_reg;
        match_next_int = match_reg;
        if (ctl.clr)
        begin
            vld_next       = 1'b0;
            match_next_int = 1'b0;
        end
        else if (ctl.step)
        begin
            data_next      = top ? in_byte : hi_data;
            vld_next       = top | hi_vld;
            match_next_int = hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg   <= pre_act;
            exp_reg   <= pre_exp;
            vld_reg   <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            act_reg   <= act_next;
            exp_reg   <= exp_next;
            vld_reg   <= vld_next;
            match_reg <= match_next_int;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign act        = act_reg;
    assign data       = data_reg;
    assign vld        = vld_reg;
    assign match      = match_reg;
    assign match_next = hit;

endmodule

`default_nettype wire

// File: rtl/mpu_ctrl.sv
// ----------------------------------------------------------------------------
// mpu_ctrl
// Phase sequencer: boundary capture, keyword and blank-line search, content
// phase. Drives the cell chain and forms at most one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

module mpu_ctrl
    import mpu_pkg::*;
#(
    parameter int MAX_BOUNDARY = 128
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       body_start,
    input  wire logic       win_vld,
    input  wire logic [7:0] win_data,
    input  wire logic       win_match,
    output cell_ctrl_t      cell_ctl,
    output result_t         res
);

    localparam int LEN_W = $clog2(MAX_BOUNDARY + 1);
    localparam logic [LEN_W:0] MAX_L = (LEN_W + 1)'(MAX_BOUNDARY);

    phase_t           phase_reg, phase_next, phase_e;
    logic             skip_reg, skip_next, skip_e;
    logic [3:0]       kp_reg, kp_next, kp_e;
    logic [LEN_W-1:0] len_reg, len_next, len_e;
    logic [LEN_W:0]   len_x;

    logic store_one, store_two, cap_fail, cap_line_end;
    logic name_hit, blank_hit;

    assign phase_e = body_start ? PH_CAPTURE : phase_reg;
    assign skip_e  = body_start ? 1'b0 : skip_reg;
    assign kp_e    = body_start ? 4'd0 : kp_reg;
    assign len_e   = body_start ? '0 : len_reg;
    assign len_x   = {1'b0, len_e};

    assign name_hit  = (kp_e < NAME_KEY_LEN) && (in_byte == name_key(kp_e));
    assign blank_hit = (kp_e < BLANK_KEY_LEN) && (in_byte == blank_key(kp_e[1:0]));

    // Boundary capture decode. A lone CR is stored late, together with the
    // byte after it when that byte is not another CR.
    always_comb
    begin
        store_one    = 1'b0;
        store_two    = 1'b0;
        cap_fail     = 1'b0;
        cap_line_end = 1'b0;
        if (skip_e)
        begin
            if (in_byte == CHAR_LF)
                cap_line_end = 1'b1;
            else if (len_x >= MAX_L)
                cap_fail = 1'b1;
            else if (in_byte == CHAR_CR)
                store_one = 1'b1;
            else if (len_x + 1'b1 >= MAX_L)
                cap_fail = 1'b1;
            else
                store_two = 1'b1;
        end
        else if (in_byte != CHAR_CR)
        begin
            if (len_x >= MAX_L)
                cap_fail = 1'b1;
            else
                store_one = 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        phase_next = phase_e;
        skip_next  = skip_e;
        kp_next    = kp_e;
        len_next   = len_e;
        case (phase_e)
            PH_CAPTURE:
            begin
                skip_next = (in_byte == CHAR_CR) && !cap_line_end;
                if (cap_fail)
                    phase_next = PH_DONE;
                else if (cap_line_end)
                begin
                    phase_next = PH_FIND_NAME;
                    kp_next    = 4'd0;
                end
                else if (store_two)
                    len_next = LEN_W'(len_x + 2'd2);
                else if (store_one)
                    len_next = LEN_W'(len_x + 1'b1);
            end
            PH_FIND_NAME:
            begin
                if (name_hit)
                begin
                    if (kp_e + 4'd1 == NAME_KEY_LEN)
                    begin
                        phase_next = PH_SKIP_LINE;
                        kp_next    = 4'd0;
                        skip_next  = 1'b0;
                    end
                    else
                        kp_next = kp_e + 4'd1;
                end
                else
                    kp_next = (in_byte == CHAR_F) ? 4'd1 : 4'd0;
            end
            PH_SKIP_LINE:
            begin
                if (skip_e)
                begin
                    skip_next  = 1'b0;
                    phase_next = PH_FIND_BLANK;
                    kp_next    = 4'd0;
                end
                else if (in_byte == CHAR_CR)
                    skip_next = 1'b1;
            end
            PH_FIND_BLANK:
            begin
                if (blank_hit)
                begin
                    if (kp_e + 4'd1 == BLANK_KEY_LEN)
                    begin
                        phase_next = PH_CONTENT;
                        kp_next    = 4'd0;
                    end
                    else
                        kp_next = kp_e + 4'd1;
                end
                else
                    kp_next = (in_byte == CHAR_CR) ? 4'd1 : 4'd0;
            end
            PH_CONTENT:
            begin
                if (win_match)
                    phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = phase_e;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cell_ctl         = '0;
        cell_ctl.restart = accept & body_start;
        res              = '0;
        case (phase_e)
            PH_CAPTURE:
            begin
                cell_ctl.shift1 = accept & store_one;
                cell_ctl.shift2 = accept & store_two;
                if (cap_fail)
                begin
                    res.valid = accept;
                    res.done  = 1'b1;
                    res.ovf   = 1'b1;
                end
            end
            PH_FIND_BLANK:
            begin
                cell_ctl.clr = accept & blank_hit & (kp_e + 4'd1 == BLANK_KEY_LEN);
            end
            PH_CONTENT:
            begin
                cell_ctl.step = accept;
                res.valid     = accept & (win_vld | win_match);
                res.has       = win_vld;
                res.data      = win_vld ? win_data : 8'h00;
                res.done      = win_match;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CAPTURE;
            skip_reg  <= 1'b0;
            kp_reg    <= 4'd0;
            len_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            kp_reg    <= kp_next;
            len_reg   <= len_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/multipart_upload_extractor.sv
// ----------------------------------------------------------------------------
// multipart_upload_extractor
// Pulls the file content out of a multipart upload body, one byte a request.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall): in_byte plus body_start, which marks
//   the first byte of a new body and restarts the parser on that byte.
//   Result channel (res_valid/res_stall): content_byte/has_byte, done_res on
//   the result that ends the content, overflow when the boundary line does
//   not fit in MAX_BOUNDARY bytes.
//   Throughput: one byte per cycle in every phase while req_stall is low. Results
//   are registered before they are shown; content bytes come out boundary length
//   plus two bytes behind the input, set by the cell chain that holds the
//   delay window and the running boundary match (MAX_BOUNDARY + 2 cells).
//   Bytes that cause no result are absorbed without output.
//   Reset: parser waits for the boundary line; no clearing pass is needed.
//   Stall: results sit in an output register with one skid entry; requests
//   are stalled only while the skid entry is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module multipart_upload_extractor
    import mpu_pkg::*;
#(
    parameter int MAX_BOUNDARY = 128
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       body_start,
    output logic            res_valid,
    input  wire logic       res_stall,
    output logic [7:0]      content_byte,
    output logic            has_byte,
    output logic            done_res,
    output logic            overflow
);

    localparam int NCELL = MAX_BOUNDARY + 2;

    logic       accept;
    cell_ctrl_t cell_ctl;
    result_t    res;

    // Base values with two virtual positions below cell 0.
    logic       ab [NCELL+1:0];
    logic [7:0] eb [NCELL+1:0];
    // Registered values with a zero position above the last cell.
    logic       ah [NCELL:0];
    logic [7:0] dh [NCELL:0];
    logic       vh [NCELL:0];
    logic       mh [NCELL:0];
    logic       mn [NCELL-1:0];

    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    assign accept = req_valid & ~req_stall;

    assign ab[0] = 1'b1;
    assign ab[1] = 1'b1;
    assign eb[0] = in_byte;
    assign eb[1] = cell_ctl.shift2 ? CHAR_CR : in_byte;

    assign ah[NCELL] = 1'b0;
    assign dh[NCELL] = 8'h00;
    assign vh[NCELL] = 1'b0;
    assign mh[NCELL] = 1'b0;

    mpu_ctrl #(
        .MAX_BOUNDARY (MAX_BOUNDARY)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .body_start (body_start),
        .win_vld    (vh[0]),
        .win_data   (dh[0]),
        .win_match  (mn[0]),
        .cell_ctl   (cell_ctl),
        .res        (res)
    );

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        localparam logic       PRE_ACT = (k < 2) ? 1'b1 : 1'b0;
        localparam logic [7:0] PRE_EXP = (k == 0) ? CHAR_LF : ((k == 1) ? CHAR_CR : 8'h00);

        mpu_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (cell_ctl),
            .in_byte    (in_byte),
            .pre_act    (PRE_ACT),
            .pre_exp    (PRE_EXP),
            .lo1_act    (ab[k+1]),
            .lo1_exp    (eb[k+1]),
            .lo2_act    (ab[k]),
            .lo2_exp    (eb[k]),
            .hi_act     (ah[k+1]),
            .hi_data    (dh[k+1]),
            .hi_vld     (vh[k+1]),
            .hi_match   (mh[k+1]),
            .base_act   (ab[k+2]),
            .base_exp   (eb[k+2]),
            .act        (ah[k]),
            .data       (dh[k]),
            .vld        (vh[k]),
            .match      (mh[k]),
            .match_next (mn[k])
        );
    end

    // Output register plus skid entry.
    always_comb
    begin
        out_next  = out_reg;
        skid_next = skid_reg;
        if (!out_reg.valid || !res_stall)
        begin
            if (skid_reg.valid)
            begin
                out_next        = skid_reg;
                skid_next.valid = 1'b0;
            end
            else
                out_next = res;
        end
        else if (res.valid)
            skid_next = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg  <= '0;
            skid_reg <= '0;
        end
        else
        begin
            out_reg  <= out_next;
            skid_reg <= skid_next;
        end
    end

    assign req_stall    = skid_reg.valid;
    assign res_valid    = out_reg.valid;
    assign content_byte = out_reg.data;
    assign has_byte     = out_reg.has;
    assign done_res     = out_reg.done;
    assign overflow     = out_reg.ovf;

    `ASSERT_IMPLY(a_skid_behind_out, skid_reg.valid, out_reg.valid, "skid full, output empty")
    `ASSERT_IMPLY(a_ovf_no_byte, res_valid && overflow, !has_byte && done_res,
                  "overflow result carries data")
    `ASSERT_IMPLY(a_result_meaning, res_valid && !has_byte, done_res && content_byte == 8'h00,
                  "empty result without end mark")
    `ASSERT_ALWAYS(a_crlf_cells, ah[0] && ah[1], "CR LF cells dropped out of the window")
    `ASSERT_NEXT(a_skid_stalls, skid_reg.valid && res_stall, req_stall,
                 "request taken while skid entry waits")

endmodule

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for multipart_upload_extractor: a short table of
// directed requests, then random multipart bodies (well-formed, broken, cut
// short, oversized boundary), checked result by result against a
// byte-level parser model, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpu_pkg::*;

    localparam int MAX_B        = 128;
    localparam int ITEM_TARGET  = 1300;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_CYCLES = 400000;

    localparam logic [71:0] NAME_KEY = "filename=";
    localparam logic [7:0]  DASH     = 8'h2D;
    localparam result_t     NO_RES   = '0;

    typedef enum int {
        K_RANDOM,
        K_OVERFLOW,
        K_LONE_CR,
        K_EMPTY,
        K_MAXB,
        K_CUT
    } body_kind_t;

    typedef struct {
        logic [7:0] b;
        logic       s;
        logic       fixed;
        result_t    r;
    } req_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       body_start = 1'b0;
    logic       res_stall = 1'b0;
    logic       req_stall;
    logic       res_valid;
    logic [7:0] content_byte;
    logic       has_byte;
    logic       done_res;
    logic       overflow;

    // expectation attached to the request currently offered (directed rows)
    logic    cur_fixed = 1'b0;
    result_t cur_want = '0;

    req_item_t  req_q[$];
    logic [7:0] body_q[$];
    result_t    want_q[$];

    int  errors = 0;
    int  cycles = 0;
    int  holds_asked = 0;
    int  holds_served = 0;
    bit  send_quiet = 1'b0;
    bit  recv_quiet = 1'b0;

    // parser model state
    phase_t     st_phase = PH_CAPTURE;
    logic [7:0] bnd_mem [0:MAX_B-1];
    int         bnd_len = 0;
    logic [7:0] win_mem [0:MAX_B+1];
    int         win_fill = 0;
    int         key_pos = 0;
    bit         cr_seen = 1'b0;

    multipart_upload_extractor #(
        .MAX_BOUNDARY(MAX_B)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .in_byte     (in_byte),
        .body_start  (body_start),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .content_byte(content_byte),
        .has_byte    (has_byte),
        .done_res    (done_res),
        .overflow    (overflow)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic bit keep_boundary_byte(input logic [7:0] b);
        if (bnd_len >= MAX_B)
            return 1'b0;
        bnd_mem[bnd_len] = b;
        bnd_len++;
        return 1'b1;
    endfunction

    // Advance the parser model by one byte; r.valid tells whether a result is due.
    function automatic result_t parse_byte(input logic [7:0] b, input logic s);
        result_t r;
        int      span;
        int      i;
        bit      hit;
        r = '0;
        if (s)
        begin
            st_phase = PH_CAPTURE;
            bnd_len  = 0;
            win_fill = 0;
            key_pos  = 0;
            cr_seen  = 1'b0;
        end
        case (st_phase)
            PH_CAPTURE:
            begin
                if (cr_seen)
                begin
                    cr_seen = 1'b0;
                    if (b == CHAR_LF)
                    begin
                        st_phase = PH_FIND_NAME;
                        key_pos  = 0;
                        return r;
                    end
                    // lone CR belongs to the boundary
                    if (!keep_boundary_byte(CHAR_CR))
                    begin
                        st_phase = PH_DONE;
                        r.valid = 1'b1;
                        r.done  = 1'b1;
                        r.ovf   = 1'b1;
                        return r;
                    end
                end
                if (b == CHAR_CR)
                begin
                    cr_seen = 1'b1;
                    return r;
                end
                if (!keep_boundary_byte(b))
                begin
                    st_phase = PH_DONE;
                    r.valid = 1'b1;
                    r.done  = 1'b1;
                    r.ovf   = 1'b1;
                end
            end
            PH_FIND_NAME:
            begin
                if (key_pos < int'(NAME_KEY_LEN) && b == NAME_KEY[71-8*key_pos -: 8])
                begin
                    key_pos++;
                    if (key_pos == int'(NAME_KEY_LEN))
                    begin
                        st_phase = PH_SKIP_LINE;
                        key_pos  = 0;
                        cr_seen  = 1'b0;
                    end
                end
                else
                    key_pos = (b == CHAR_F) ? 1 : 0;
            end
            PH_SKIP_LINE:
            begin
                if (cr_seen)
                begin
                    cr_seen  = 1'b0;
                    st_phase = PH_FIND_BLANK;
                    key_pos  = 0;
                end
                else if (b == CHAR_CR)
                    cr_seen = 1'b1;
            end
            PH_FIND_BLANK:
            begin
                if (key_pos < int'(BLANK_KEY_LEN) &&
                    b == ((key_pos % 2 == 0) ? CHAR_CR : CHAR_LF))
                begin
                    key_pos++;
                    if (key_pos == int'(BLANK_KEY_LEN))
                    begin
                        st_phase = PH_CONTENT;
                        key_pos  = 0;
                        win_fill = 0;
                    end
                end
                else
                    key_pos = (b == CHAR_CR) ? 1 : 0;
            end
            PH_CONTENT:
            begin
                span = bnd_len + 2;
                if (win_fill >= span)
                begin
                    r.data = win_mem[0];
                    for (i = 0; i < span - 1; i++)
                        win_mem[i] = win_mem[i+1];
                    win_mem[span-1] = b;
                    r.has = 1'b1;
                end
                else
                begin
                    win_mem[win_fill] = b;
                    win_fill++;
                end
                if (win_fill == span && win_mem[0] == CHAR_CR && win_mem[1] == CHAR_LF)
                begin
                    hit = 1'b1;
                    for (i = 0; i < bnd_len; i++)
                        if (win_mem[2+i] != bnd_mem[i])
                            hit = 1'b0;
                    if (hit)
                    begin
                        st_phase = PH_DONE;
                        r.done = 1'b1;
                    end
                end
                r.valid = r.has | r.done;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic add_row(input logic [7:0] b, input logic s, input logic fixed,
                           input result_t r);
        req_item_t it;
        it.b     = b;
        it.s     = s;
        it.fixed = fixed;
        it.r     = r;
        req_q.push_back(it);
    endtask

    // One multipart body into the request list; counted grows by the
    // requests that the parser does not simply ignore.
    task automatic gen_body(input body_kind_t kind, inout int counted);
        logic [7:0] bnd[$];
        logic [7:0] c;
        int         blen;
        int         clen;
        int         r;
        int         i;
        int         k;
        int         tail;
        int         cut;
        body_q.delete();
        tail = 0;
        r = $urandom_range(0, 19);
        case (kind)
            K_OVERFLOW: blen = MAX_B + 1 + $urandom_range(0, 2);
            K_MAXB:     blen = MAX_B;
            K_EMPTY:    blen = $urandom_range(0, 3);
            K_LONE_CR:  blen = $urandom_range(2, 6);
            default:    blen = (r == 0) ? MAX_B : (r == 1) ? MAX_B + 1 :
                               (r < 5) ? 0 : $urandom_range(1, 8);
        endcase
        for (i = 0; i < blen; i++)
        begin
            c = 8'($urandom_range(0, 255));
            if (c == CHAR_CR)
                c = DASH;
            bnd.push_back(c);
        end
        if (blen >= 2 && blen <= MAX_B && (kind == K_LONE_CR || $urandom_range(0, 5) == 0))
        begin
            k = $urandom_range(0, blen - 1);
            bnd[k] = CHAR_CR;
            if (k + 1 < blen && bnd[k+1] == CHAR_LF)
                bnd[k+1] = DASH;
        end
        foreach (bnd[j])
            body_q.push_back(bnd[j]);
        if (blen > MAX_B)
        begin
            // everything past the overflowing byte is ignored
            tail = blen - (MAX_B + 1);
        end
        else
        begin
            body_q.push_back(CHAR_CR);
            body_q.push_back(CHAR_LF);
            k = $urandom_range(0, 6);
            for (i = 0; i < k; i++)
                body_q.push_back(8'(97 + $urandom_range(0, 25)));
            if ($urandom_range(0, 2) == 0)
            begin
                for (i = 0; i < 4; i++)
                    body_q.push_back(NAME_KEY[71-8*i -: 8]);
                body_q.push_back(8'h78);
            end
            for (i = 0; i < int'(NAME_KEY_LEN); i++)
                body_q.push_back(NAME_KEY[71-8*i -: 8]);
            k = $urandom_range(0, 5);
            for (i = 0; i < k; i++)
            begin
                c = 8'($urandom_range(0, 255));
                body_q.push_back((c == CHAR_CR) ? DASH : c);
            end
            body_q.push_back(CHAR_CR);
            body_q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : CHAR_LF);
            k = $urandom_range(0, 5);
            for (i = 0; i < k; i++)
            begin
                c = 8'($urandom_range(0, 255));
                body_q.push_back((c == CHAR_CR) ? DASH : c);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                // three quarters of a blank line, then a break
                body_q.push_back(CHAR_CR);
                body_q.push_back(CHAR_LF);
                body_q.push_back(CHAR_CR);
                body_q.push_back(8'h78);
            end
            body_q.push_back(CHAR_CR);
            body_q.push_back(CHAR_LF);
            body_q.push_back(CHAR_CR);
            body_q.push_back(CHAR_LF);
            if (kind == K_EMPTY)
                clen = 0;
            else
                clen = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                   : $urandom_range(0, 40);
            for (i = 0; i < clen; i++)
            begin
                r = $urandom_range(0, 19);
                if (r == 0 && blen > 0)
                begin
                    // delimiter with its last byte off by one bit
                    body_q.push_back(CHAR_CR);
                    body_q.push_back(CHAR_LF);
                    for (k = 0; k < blen - 1; k++)
                        body_q.push_back(bnd[k]);
                    body_q.push_back(bnd[blen-1] ^ 8'h01);
                end
                else if (r == 1 && blen > 0)
                begin
                    // CR without LF ahead of the boundary must not end content
                    c = 8'($urandom_range(0, 255));
                    body_q.push_back(CHAR_CR);
                    body_q.push_back((c == CHAR_LF) ? 8'h0B : c);
                    foreach (bnd[j])
                        body_q.push_back(bnd[j]);
                end
                else if (r < 4)
                    body_q.push_back(CHAR_CR);
                else if (r < 6)
                    body_q.push_back(CHAR_LF);
                else if (r < 8 && blen > 0)
                    body_q.push_back(bnd[$urandom_range(0, blen - 1)]);
                else
                    body_q.push_back(8'($urandom_range(0, 255)));
            end
            if (kind != K_CUT && $urandom_range(0, 9) != 0)
            begin
                body_q.push_back(CHAR_CR);
                body_q.push_back(CHAR_LF);
                foreach (bnd[j])
                    body_q.push_back(bnd[j]);
                tail = $urandom_range(0, 3);
                for (i = 0; i < tail; i++)
                    body_q.push_back(8'($urandom_range(0, 255)));
            end
            if (kind == K_CUT || (kind == K_RANDOM && $urandom_range(0, 9) == 0))
            begin
                cut = $urandom_range(1, body_q.size() - 1);
                body_q = body_q[0:cut-1];
                tail = 0;
            end
        end
        foreach (body_q[j])
            add_row(body_q[j], (j == 0), 1'b0, NO_RES);
        counted += body_q.size() - tail;
    endtask

    initial
    begin : drive
        req_item_t it;
        int        gap;
        int        sent;
        int        hold_at;
        int        counted;
        int        m;
        sent = 0;
        hold_at = 300;
        counted = 0;

        // directed: empty boundary, content 00 FF ended by CR LF
        add_row(CHAR_CR, 1'b0, 1'b1, NO_RES);
        add_row(CHAR_LF, 1'b0, 1'b0, NO_RES);
        for (m = 0; m < int'(NAME_KEY_LEN); m++)
            add_row(NAME_KEY[71-8*m -: 8], 1'b0, 1'b0, NO_RES);
        add_row(CHAR_CR, 1'b0, 1'b0, NO_RES);
        add_row(8'hFF, 1'b0, 1'b0, NO_RES);
        add_row(CHAR_CR, 1'b0, 1'b0, NO_RES);
        add_row(CHAR_LF, 1'b0, 1'b0, NO_RES);
        add_row(CHAR_CR, 1'b0, 1'b0, NO_RES);
        add_row(CHAR_LF, 1'b0, 1'b0, NO_RES);
        add_row(8'h00, 1'b0, 1'b0, NO_RES);
        add_row(8'hFF, 1'b0, 1'b0, NO_RES);
        add_row(CHAR_CR, 1'b0, 1'b1, '{1'b1, 8'h00, 1'b1, 1'b0, 1'b0});
        add_row(CHAR_LF, 1'b0, 1'b1, '{1'b1, 8'hFF, 1'b1, 1'b1, 1'b0});
        add_row(8'h41, 1'b0, 1'b1, NO_RES);
        add_row(CHAR_CR, 1'b1, 1'b1, NO_RES);

        // random bodies; the first few walk the corner cases in turn
        m = 0;
        while (counted < ITEM_TARGET)
        begin
            gen_body((m < 5) ? body_kind_t'(m + 1) : K_RANDOM, counted);
            m++;
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_q.size() != 0)
        begin
            it = req_q.pop_front();
            if ($urandom_range(0, 59) == 0)
                send_quiet = !send_quiet;
            gap = send_quiet ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                req_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_byte    = it.b;
            body_start = it.s;
            cur_fixed  = it.fixed;
            cur_want   = it.r;
            req_valid  = 1'b1;
            @(posedge clk);
            while (req_stall)
                @(posedge clk);
            @(negedge clk);
            sent++;
            // long receiver hold-off in the middle of content
            if (holds_asked < 2 && sent >= hold_at && st_phase == PH_CONTENT)
            begin
                holds_asked++;
                hold_at = sent + 500;
            end
        end
        req_valid = 1'b0;
        cur_fixed = 1'b0;

        while (want_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : recv
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_asked > holds_served)
            begin
                res_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_served++;
            end
            if ($urandom_range(0, 39) == 0)
                recv_quiet = !recv_quiet;
            n = recv_quiet ? 0 : $urandom_range(0, 14);
            if (n > 0)
            begin
                res_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            res_stall = 1'b0;
            do
                @(posedge clk);
            while (!res_valid);
        end
    end

    // predict on every accepted request first, then check the accepted result
    always @(posedge clk)
    begin : check
        result_t pred;
        result_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                pred = parse_byte(in_byte, body_start);
                if (cur_fixed)
                    pred = cur_want;
                if (pred.valid)
                    want_q.push_back(pred);
            end
            if (res_valid && !res_stall)
            begin
                if (want_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: byte=%h has=%b done=%b ovf=%b",
                                 content_byte, has_byte, done_res, overflow);
                end
                else
                begin
                    want = want_q.pop_front();
                    if (content_byte !== want.data || has_byte !== want.has ||
                        done_res !== want.done || overflow !== want.ovf)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected byte=%h has=%b done=%b ovf=%b,",
                                     want.data, want.has, want.done, want.ovf,
                                     " got byte=%h has=%b done=%b ovf=%b",
                                     content_byte, has_byte, done_res, overflow);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire
